// File: src/dfgc_pkg.sv
// Shared types and constants for the drop-oldest descriptor FIFO with gap counter.
// No dependencies; used by every module under src.
package dfgc_pkg;

	localparam int QUEUE_DEPTH_DEF = 1024;
	localparam int WORD_W          = 32;
	localparam int FILL_W          = 11;
	localparam int MODE_W          = 2;
	localparam int ENTRY_W         = 2 * WORD_W;
	localparam int S_TDATA_W       = 64;
	localparam int M_TDATA_W       = 208;
	localparam logic [FILL_W-1:0] FILL_LIMIT_RST = 11'd1024;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH  = 2'd0,
		MODE_POP   = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	// one result transaction, item_descriptor in the lowest bits
	typedef struct packed {
		logic              item_valid;
		logic [WORD_W-1:0] latest_seq;
		logic [WORD_W-1:0] gap_count;
		logic [WORD_W-1:0] dropped_count;
		logic [WORD_W-1:0] received_count;
		logic [FILL_W-1:0] fill_level;
		logic [WORD_W-1:0] item_seq;
		logic [WORD_W-1:0] item_descriptor;
	} result_t;

	// controller -> datapath / output buffer
	typedef struct packed {
		logic load;  // input transaction accepted: latch it, start head read
		logic exec;  // apply latched item, push result to output buffer
	} dp_cmd_t;

	// output buffer -> controller
	typedef struct packed {
		logic buf_room;
	} ob_status_t;

endpackage

// File: src/dfgc_ctrl.sv
// Controller FSM: accepts one input transaction, then runs an execute cycle.
// Depends on dfgc_pkg (dp_cmd_t, ob_status_t).
module dfgc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dfgc_pkg::ob_status_t status,
	output dfgc_pkg::dp_cmd_t    cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE) && status.buf_room;
	assign cmd.load = in_valid && in_ready;
	assign cmd.exec = (state_q == ST_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/dfgc_datapath.sv
// Datapath: entry memory, head/tail/occupancy, statistics counters, fill limit.
// Depends on dfgc_pkg; driven by dfgc_ctrl commands.
module dfgc_datapath #(
	parameter int QUEUE_DEPTH = dfgc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dfgc_pkg::dp_cmd_t                cmd,
	input  logic [dfgc_pkg::MODE_W-1:0]      in_mode,
	input  logic [dfgc_pkg::WORD_W-1:0]      in_seq,
	input  logic [dfgc_pkg::WORD_W-1:0]      in_desc,
	input  logic                             cfg_we,
	input  logic [dfgc_pkg::FILL_W-1:0]      cfg_wdata,
	output dfgc_pkg::result_t                result
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	localparam int CW = (OW > dfgc_pkg::FILL_W) ? OW : dfgc_pkg::FILL_W;
	localparam logic [PW-1:0] LAST_IDX = PW'(QUEUE_DEPTH - 1);
	localparam int WORD_W_L = dfgc_pkg::WORD_W;
	localparam logic [WORD_W_L-1:0] SAT_MAX = '1;

	function automatic logic [WORD_W_L-1:0] sat_inc(input logic [WORD_W_L-1:0] v);
		return (v == SAT_MAX) ? v : v + WORD_W_L'(1);
	endfunction

	function automatic logic [PW-1:0] next_idx(input logic [PW-1:0] p);
		return (p == LAST_IDX) ? '0 : p + PW'(1);
	endfunction

	logic [dfgc_pkg::ENTRY_W-1:0] entry_mem_q [QUEUE_DEPTH];
	logic [dfgc_pkg::ENTRY_W-1:0] rd_data_q;

	dfgc_pkg::mode_t              mode_q;
	logic [WORD_W_L-1:0]          seq_q, desc_q;
	logic [PW-1:0]                head_q, tail_q, head_n, tail_n;
	logic [OW-1:0]                occ_q, occ_n;
	logic [WORD_W_L-1:0]          recv_q, drop_q, gap_q, last_q;
	logic [WORD_W_L-1:0]          recv_n, drop_n, gap_n, last_n;
	logic [dfgc_pkg::FILL_W-1:0]  fill_limit_q;

	logic [CW-1:0] lim_ext, eff_lim;
	logic          full_hit, push_we, pop_hit;

	always_comb begin
		lim_ext = CW'(fill_limit_q);
		if (lim_ext == '0)
			eff_lim = CW'(1);
		else if (lim_ext > CW'(QUEUE_DEPTH))
			eff_lim = CW'(QUEUE_DEPTH);
		else
			eff_lim = lim_ext;
		full_hit = (CW'(occ_q) >= eff_lim) && (occ_q != '0);
	end

	always_comb begin
		head_n  = head_q;
		tail_n  = tail_q;
		occ_n   = occ_q;
		recv_n  = recv_q;
		drop_n  = drop_q;
		gap_n   = gap_q;
		last_n  = last_q;
		push_we = 1'b0;
		pop_hit = 1'b0;
		case (mode_q)
			dfgc_pkg::MODE_PUSH: begin
				push_we = cmd.exec;
				if ((recv_q != '0) && (last_q != '0) && (seq_q != last_q + WORD_W_L'(1)))
					gap_n = sat_inc(gap_q);
				last_n = seq_q;
				recv_n = sat_inc(recv_q);
				tail_n = next_idx(tail_q);
				if (full_hit) begin
					// drop oldest, fill stays
					head_n = next_idx(head_q);
					drop_n = sat_inc(drop_q);
				end else begin
					occ_n = occ_q + OW'(1);
				end
			end
			dfgc_pkg::MODE_POP: begin
				if (occ_q != '0) begin
					pop_hit = 1'b1;
					head_n  = next_idx(head_q);
					occ_n   = occ_q - OW'(1);
				end
			end
			dfgc_pkg::MODE_CLEAR: begin
				recv_n = '0;
				drop_n = '0;
				gap_n  = '0;
				last_n = '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		result.item_valid      = pop_hit;
		result.item_descriptor = pop_hit ? rd_data_q[WORD_W_L-1:0] : '0;
		result.item_seq        = pop_hit ? rd_data_q[2*WORD_W_L-1:WORD_W_L] : '0;
		result.fill_level      = dfgc_pkg::FILL_W'(occ_n);
		result.received_count  = recv_n;
		result.dropped_count   = drop_n;
		result.gap_count       = gap_n;
		result.latest_seq      = last_n;
	end

	// entry memory: one write, one registered read at the head
	always_ff @(posedge clk) begin
		if (push_we) entry_mem_q[tail_q] <= {seq_q, desc_q};
		if (cmd.load) rd_data_q <= entry_mem_q[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= dfgc_pkg::mode_t'(in_mode);
			seq_q  <= in_seq;
			desc_q <= in_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			occ_q        <= '0;
			recv_q       <= '0;
			drop_q       <= '0;
			gap_q        <= '0;
			last_q       <= '0;
			fill_limit_q <= dfgc_pkg::FILL_LIMIT_RST;
		end else begin
			if (cfg_we) fill_limit_q <= cfg_wdata;
			if (cmd.exec) begin
				head_q <= head_n;
				tail_q <= tail_n;
				occ_q  <= occ_n;
				recv_q <= recv_n;
				drop_q <= drop_n;
				gap_q  <= gap_n;
				last_q <= last_n;
			end
		end
	end

endmodule

// File: src/dfgc_out_buf.sv
// Two-entry result buffer between the datapath and the master stream port.
// Depends on dfgc_pkg (result_t, ob_status_t).
module dfgc_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  dfgc_pkg::result_t    push_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output dfgc_pkg::result_t    out_data,
	output dfgc_pkg::ob_status_t status
);

	dfgc_pkg::result_t buf_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              pop;

	assign out_valid       = (cnt_q != 2'd0);
	assign out_data        = buf_q[rd_ptr_q];
	assign pop             = out_valid && out_ready;
	assign status.buf_room = (cnt_q != 2'd2);

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: src/drop_oldest_fifo_gap_counter_unit.sv
// Top level: drop-oldest descriptor FIFO with sequence gap counter.
// Depends on dfgc_pkg, dfgc_ctrl, dfgc_datapath, dfgc_out_buf.
//
// Usage
//   Input stream (s_axis_*): one operation per transaction. tuser carries the
//   mode (push, pop, clear statistics, other code = no-op); tdata carries the
//   sequence number and descriptor used by a push.
//   Output stream (m_axis_*): exactly one result transaction per input
//   transaction, in order. tuser flags a popped entry; tdata carries the
//   popped entry (zero when none), fill level and the saturating counters.
//   cfg_we/cfg_wdata: writes fill_limit (0 acts as 1, above QUEUE_DEPTH acts
//   as QUEUE_DEPTH); write only while idle.
// Timing
//   Accept, then execute in the next cycle; the result is then written into
//   the result buffer and shown on m_axis. No new item is accepted while one
//   executes: the head entry is read from the entry RAM through its registered
//   read port in the accept cycle and used in the execute cycle.
// Reset and stalls
//   arst_n empties the queue, zeroes counters and sets fill_limit to 1024;
//   RAM contents are not cleared. A two-deep result buffer lets one more item
//   be accepted while a result waits; with both slots full s_axis_tready drops.
module drop_oldest_fifo_gap_counter_unit #(
	parameter int QUEUE_DEPTH = dfgc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [31:0] seq_number, [63:32] descriptor
	input  logic [dfgc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// [1:0] mode
	input  logic [dfgc_pkg::MODE_W-1:0]      s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [31:0] item_descriptor, [63:32] item_seq, [74:64] fill_level,
	// [106:75] received_count, [138:107] dropped_count, [170:139] gap_count,
	// [202:171] latest_seq, [207:203] zero
	output logic [dfgc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	// [0] item_valid
	output logic                             m_axis_tuser,
	input  logic                             cfg_we,
	input  logic [dfgc_pkg::FILL_W-1:0]      cfg_wdata
);

	localparam int W = dfgc_pkg::WORD_W;

	dfgc_pkg::dp_cmd_t    cmd;
	dfgc_pkg::ob_status_t ob_status;
	dfgc_pkg::result_t    dp_result;
	dfgc_pkg::result_t    out_res;

	dfgc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (ob_status),
		.cmd      (cmd)
	);

	dfgc_datapath #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_mode   (s_axis_tuser),
		.in_seq    (s_axis_tdata[W-1:0]),
		.in_desc   (s_axis_tdata[2*W-1:W]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (dp_result)
	);

	// one result per execute cycle
	dfgc_out_buf u_ob (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd.exec),
		.push_data (dp_result),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res),
		.status    (ob_status)
	);

	assign m_axis_tuser = out_res.item_valid;
	assign m_axis_tdata = {5'd0,
		out_res.latest_seq,
		out_res.gap_count,
		out_res.dropped_count,
		out_res.received_count,
		out_res.fill_level,
		out_res.item_seq,
		out_res.item_descriptor};

endmodule

// File: src/dfgc_checker.sv
// Port-level checker for drop_oldest_fifo_gap_counter_unit, bound to the top.
// Depends on dfgc_pkg for port widths.
module dfgc_checker #(
	parameter int QUEUE_DEPTH = dfgc_pkg::QUEUE_DEPTH_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [dfgc_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// no entry returned: entry fields are zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:0] == 64'd0)
		else $error("entry fields nonzero without popped entry");

	// fill never exceeds the queue depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> 32'(m_axis_tdata[74:64]) <= 32'(QUEUE_DEPTH))
		else $error("fill level above depth");

	// an execute cycle follows every accepted item
	a_exec_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted during execute cycle");

endmodule

bind drop_oldest_fifo_gap_counter_unit dfgc_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_dfgc_checker (.*);
